### sv/npc_pkg.sv
`default_nettype none

package npc_pkg;

  // default number of palette cells in the chain
  localparam int PaletteDepthDflt = 256;

  // field widths
  localparam int ColorW = 8;
  localparam int IndexW = 8;
  localparam int CountW = 9;
  localparam int DistW  = 18;
  localparam int SqW    = 2 * ColorW;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MAP  = 1'b1;

  // start value of the running minimum, above any real distance
  localparam logic [DistW-1:0] DIST_START = DistW'(3 * 256 * 256);

  // reset value of color_count
  localparam logic [CountW-1:0] COUNT_RESET = CountW'(256);

  // payload carried from cell to cell
  typedef struct packed {
    logic              cmd;
    logic [IndexW-1:0] entry_index;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic              last_pixel;
    logic [IndexW-1:0] best_idx;
    logic [DistW-1:0]  best_dist;
  } stage_data_t;

  // one slot of the chain: valid flag plus payload
  typedef struct packed {
    logic        valid;
    stage_data_t data;
  } stage_t;

endpackage

`default_nettype wire

### sv/npc_cell.sv
`default_nettype none

module npc_cell import npc_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [CountW-1:0] color_count_i,
  input  stage_t            prev_i,
  output stage_t            next_o
);

  logic [3*ColorW-1:0] entry_q;
  logic                valid_q;
  stage_data_t         data_q;
  stage_data_t         data_d;

  logic [ColorW-1:0] dr, dg, db;
  logic [SqW-1:0]    sq_r, sq_g, sq_b;
  logic [DistW-1:0]  entry_dist;
  logic              is_load, is_map, in_search;

  // command decode for the item in front of this cell
  assign is_load   = prev_i.valid && (prev_i.data.cmd == CMD_LOAD);
  assign is_map    = prev_i.data.cmd == CMD_MAP;
  assign in_search = color_count_i > CountW'(INDEX);

  // absolute component differences against the stored entry
  assign dr = (entry_q[23:16] > prev_i.data.red) ? entry_q[23:16] - prev_i.data.red
                                                 : prev_i.data.red - entry_q[23:16];
  assign dg = (entry_q[15:8] > prev_i.data.green) ? entry_q[15:8] - prev_i.data.green
                                                  : prev_i.data.green - entry_q[15:8];
  assign db = (entry_q[7:0] > prev_i.data.blue) ? entry_q[7:0] - prev_i.data.blue
                                                : prev_i.data.blue - entry_q[7:0];

  // squared distance
  assign sq_r       = SqW'(dr) * SqW'(dr);
  assign sq_g       = SqW'(dg) * SqW'(dg);
  assign sq_b       = SqW'(db) * SqW'(db);
  assign entry_dist = DistW'(sq_r) + DistW'(sq_g) + DistW'(sq_b);

  // running minimum update, first entry wins on ties
  always_comb begin
    data_d = prev_i.data;
    if (is_map && in_search && (entry_dist < prev_i.data.best_dist)) begin
      data_d.best_idx  = IndexW'(INDEX);
      data_d.best_dist = entry_dist;
    end
  end

  // palette entry owned by this cell, written by a passing load
  always_ff @(posedge clk_i) begin
    if (en_i && is_load && (prev_i.data.entry_index == IndexW'(INDEX))) begin
      entry_q <= {prev_i.data.red, prev_i.data.green, prev_i.data.blue};
    end
  end

  // slot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= prev_i.valid;
    end
  end

  // slot payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign next_o.valid = valid_q;
  assign next_o.data  = data_q;

endmodule

`default_nettype wire

### sv/nearest_palette_color.sv
// channel   signals                                             direction
// input     in_valid_i in_ready_o cmd_i entry_index_i red_i       in
//           green_i blue_i last_pixel_i
// output    out_valid_o out_ready_i color_index_o distance_o      out
//           frame_last_o
// config    cfg_we_i cfg_data_i (color_count, no wait)            in
//
// one item is taken per cycle while the output is not stalled; each
// palette cell in the chain registers the item on its way through;
// the last cell's register is the output register; loads drop out there
// a stalled output freezes the whole chain, and input ready goes low with it
// reset clears the slot valid flags and sets color_count to 256; palette
// entries hold nothing defined until loaded, and no clearing pass runs

`default_nettype none

module nearest_palette_color import npc_pkg::*; #(
  parameter int PALETTE_DEPTH = PaletteDepthDflt
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [IndexW-1:0] entry_index_i,
  input  logic [ColorW-1:0] red_i,
  input  logic [ColorW-1:0] green_i,
  input  logic [ColorW-1:0] blue_i,
  input  logic              last_pixel_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IndexW-1:0] color_index_o,
  output logic [DistW-1:0]  distance_o,
  output logic              frame_last_o,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_data_i
);

  logic [CountW-1:0] color_count_q;
  logic              en;
  stage_t            chain [PALETTE_DEPTH+1];

  // color_count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      color_count_q <= cfg_data_i;
    end
  end

  // chain advances unless a result waits at the end
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // chain head built from the input transfer
  always_comb begin
    chain[0].valid            = in_valid_i;
    chain[0].data.cmd         = cmd_i;
    chain[0].data.entry_index = entry_index_i;
    chain[0].data.red         = red_i;
    chain[0].data.green       = green_i;
    chain[0].data.blue        = blue_i;
    chain[0].data.last_pixel  = last_pixel_i;
    chain[0].data.best_idx    = '0;
    chain[0].data.best_dist   = DIST_START;
  end

  // one cell per palette entry
  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    npc_cell #(
      .INDEX(k)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (en),
      .color_count_i (color_count_q),
      .prev_i        (chain[k]),
      .next_o        (chain[k+1])
    );
  end

  // result from the last cell; loads give no transfer
  assign out_valid_o   = chain[PALETTE_DEPTH].valid &&
                         (chain[PALETTE_DEPTH].data.cmd == CMD_MAP);
  assign color_index_o = chain[PALETTE_DEPTH].data.best_idx;
  assign distance_o    = chain[PALETTE_DEPTH].data.best_dist;
  assign frame_last_o  = chain[PALETTE_DEPTH].data.last_pixel;

`ifndef SYNTHESIS
  // distance never exceeds the start value
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (distance_o <= DIST_START))
    else $error("distance above start value");

  // no winner means entry zero
  a_empty_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (distance_o == DIST_START)) |-> (color_index_o == '0))
    else $error("empty search with nonzero index");

  // a stalled result stays put while the chain is frozen
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(color_index_o) && $stable(distance_o) &&
       $stable(frame_last_o)))
    else $error("result changed while stalled");

  // input is refused exactly while a result is held
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken during output stall");
`endif

endmodule

`default_nettype wire

### bench/palette_match_checker.sv
`timescale 1ns / 100ps

module palette_match_checker import npc_pkg::*; #(
  parameter int PALETTE_DEPTH = PaletteDepthDflt
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              cmd_i,
  input  logic [IndexW-1:0] entry_index_i,
  input  logic [ColorW-1:0] red_i,
  input  logic [ColorW-1:0] green_i,
  input  logic [ColorW-1:0] blue_i,
  input  logic              last_pixel_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [IndexW-1:0] color_index_i,
  input  logic [DistW-1:0]  distance_i,
  input  logic              frame_last_i,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_data_i,
  output int                mismatches_o,
  output int                pending_o
);

  typedef struct packed {
    logic [IndexW-1:0] color_index;
    logic [DistW-1:0]  distance;
    logic              frame_last;
  } match_t;

  logic [3*ColorW-1:0] palette_copy [PALETTE_DEPTH];
  logic [CountW-1:0]   color_count_q;
  match_t              match_q [$];
  int                  fail_total = 0;
  int                  match_count = 0;

  assign mismatches_o = fail_total;
  assign pending_o    = match_count;

  function automatic int unsigned chan_dist(logic [ColorW-1:0] a, logic [ColorW-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  // nearest entry among the searched ones, first one wins on a tie
  function automatic match_t closest_entry(logic [ColorW-1:0] r, logic [ColorW-1:0] g,
                                           logic [ColorW-1:0] b, logic last);
    match_t      m;
    int          searched;
    int          best;
    int          k;
    int unsigned entry_dist;
    int unsigned best_dist;
    searched  = (int'(color_count_q) > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(color_count_q);
    best      = 0;
    best_dist = 32'(DIST_START);
    for (k = 0; k < searched; k++) begin
      entry_dist = chan_dist(palette_copy[k][23:16], r) + chan_dist(palette_copy[k][15:8], g)
                 + chan_dist(palette_copy[k][7:0], b);
      if (entry_dist < best_dist) begin
        best_dist = entry_dist;
        best      = k;
      end
    end
    m.color_index = IndexW'(best);
    m.distance    = DistW'(best_dist);
    m.frame_last  = last;
    return m;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    fail_total++;
  endtask

  // watch both channels and the config port
  always @(posedge clk_i or negedge rst_ni) begin : watch
    match_t want;
    if (!rst_ni) begin
      color_count_q = COUNT_RESET;
      match_q.delete();
      match_count = 0;
    end else begin
      // result transfer against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (match_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: index %0d distance %0d",
                                    color_index_i, distance_i));
        end else begin
          want = match_q.pop_front();
          if (color_index_i !== want.color_index)
            report_mismatch($sformatf("color_index %0d, expected %0d",
                                      color_index_i, want.color_index));
          if (distance_i !== want.distance)
            report_mismatch($sformatf("distance %0d, expected %0d",
                                      distance_i, want.distance));
          if (frame_last_i !== want.frame_last)
            report_mismatch($sformatf("frame_last %0b, expected %0b",
                                      frame_last_i, want.frame_last));
        end
      end
      // input transfer: loads update the palette, maps queue a result
      if (in_valid_i && in_ready_i) begin
        if (cmd_i == CMD_LOAD) begin
          if (int'(entry_index_i) < PALETTE_DEPTH)
            palette_copy[entry_index_i] = {red_i, green_i, blue_i};
        end else begin
          match_q.insert(match_q.size(),
                         closest_entry(red_i, green_i, blue_i, last_pixel_i));
        end
      end
      if (cfg_we_i) begin
        color_count_q = cfg_data_i;
      end
      match_count = match_q.size();
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import npc_pkg::*;

  localparam int Depth       = PaletteDepthDflt;
  localparam int DrainCycles = Depth + 32;
  localparam int LongHold    = 1500;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              cmd_i;
  logic [IndexW-1:0] entry_index_i;
  logic [ColorW-1:0] red_i;
  logic [ColorW-1:0] green_i;
  logic [ColorW-1:0] blue_i;
  logic              last_pixel_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [IndexW-1:0] color_index_o;
  logic [DistW-1:0]  distance_o;
  logic              frame_last_o;
  logic              cfg_we_i;
  logic [CountW-1:0] cfg_data_i;

  int                mismatches;
  int                pending;

  // stimulus-side copy of the palette, used to aim pixels near entries
  logic [3*ColorW-1:0] loaded_colors [Depth];
  int                  burst_left = 0;
  logic                ready_hold = 1'b0;
  logic                hold_req   = 1'b0;

  nearest_palette_color #(
    .PALETTE_DEPTH(Depth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .last_pixel_i  (last_pixel_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .color_index_o (color_index_o),
    .distance_o    (distance_o),
    .frame_last_o  (frame_last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i)
  );

  palette_match_checker #(
    .PALETTE_DEPTH(Depth)
  ) match_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .last_pixel_i  (last_pixel_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .color_index_i (color_index_o),
    .distance_i    (distance_o),
    .frame_last_i  (frame_last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: alternating ready runs and stalls, one long hold-off on request
  initial begin : receiver
    int   run_left;
    int   hold_cnt;
    logic run_on;
    logic hold_done;
    run_left    = 0;
    hold_cnt    = 0;
    run_on      = 1'b0;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_cnt  = LongHold;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (ready_hold) begin
        out_ready_i <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_on   = !run_on;
          run_left = run_on ? $urandom_range(1, 40) : $urandom_range(1, 10);
        end
        run_left--;
        out_ready_i <= run_on;
      end
    end
  end

  function automatic logic [ColorW-1:0] nudge(logic [ColorW-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return ColorW'(v);
  endfunction

  function automatic logic [ColorW-1:0] rail();
    return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
  endfunction

  // one input transfer, preceded by a random gap between bursts
  task automatic send_item(logic cmd, logic [IndexW-1:0] idx, logic [3*ColorW-1:0] rgb,
                           logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    entry_index_i <= idx;
    red_i         <= rgb[23:16];
    green_i       <= rgb[15:8];
    blue_i        <= rgb[7:0];
    last_pixel_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic load_entry(logic [IndexW-1:0] idx, logic [3*ColorW-1:0] rgb);
    loaded_colors[idx] = rgb;
    send_item(CMD_LOAD, idx, rgb, 1'($urandom_range(0, 1)));
  endtask

  task automatic map_pixel(logic [3*ColorW-1:0] rgb, logic last);
    send_item(CMD_MAP, IndexW'($urandom_range(0, 255)), rgb, last);
  endtask

  task automatic results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  // loads still in the chain leave no result, so give them time to fall out
  task automatic block_idle();
    results_drained();
    ready_hold = 1'b1;
    repeat (DrainCycles) @(posedge clk_i);
    ready_hold = 1'b0;
  endtask

  task automatic set_color_count(logic [CountW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // mostly maps, some aimed at or near loaded colors, plus reloads that may copy an entry to create ties
  task automatic random_item();
    logic [3*ColorW-1:0] c;
    int                  pick;
    pick = $urandom_range(0, 5);
    c    = loaded_colors[IndexW'($urandom_range(0, Depth - 1))];
    if ($urandom_range(0, 9) < 7) begin
      if (pick <= 1)
        c = {nudge(c[23:16]), nudge(c[15:8]), nudge(c[7:0])};
      else if (pick == 2)
        c = {rail(), rail(), rail()};
      else if (pick != 3)
        c = 24'($urandom);
      map_pixel(c, 1'($urandom_range(0, 1)));
    end else begin
      if (pick == 1)
        c = {rail(), rail(), rail()};
      else if (pick > 2)
        c = 24'($urandom);
      load_entry(IndexW'($urandom_range(0, Depth - 1)), c);
    end
  endtask

  task automatic run_phase(logic [CountW-1:0] count, int items, bit long_hold, bit pause_mid);
    block_idle();
    set_color_count(count);
    if (long_hold) hold_req = 1'b1;
    for (int i = 0; i < items; i++) begin
      if (pause_mid && i == items / 2) results_drained();
      random_item();
    end
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_LOAD;
    entry_index_i = '0;
    red_i         = '0;
    green_i       = '0;
    blue_i        = '0;
    last_pixel_i  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty search
    set_color_count('0);
    map_pixel(24'h000000, 1'b0);
    map_pixel(24'hFFFFFF, 1'b1);

    // small palette with a duplicate entry for ties
    load_entry(8'd0, 24'h000000);
    load_entry(8'd1, 24'hFFFFFF);
    load_entry(8'd2, 24'h808080);
    load_entry(8'd3, 24'hFFFFFF);
    load_entry(8'd255, 24'h5AA5C3);

    // single entry: entry zero wins even at the largest distance
    block_idle();
    set_color_count(CountW'(1));
    map_pixel(24'hFFFFFF, 1'b1);

    block_idle();
    set_color_count(CountW'(4));
    map_pixel(24'hFFFFFF, 1'b0);
    map_pixel(24'h000000, 1'b1);
    map_pixel(24'h808080, 1'b0);
    map_pixel(24'hC8C8C8, 1'b1);
    map_pixel(24'h404040, 1'b0);
    map_pixel(24'hFF00FF, 1'b1);
    map_pixel(24'h00FF00, 1'b0);

    // fill the whole palette before any wide search
    for (int k = 0; k < Depth; k++) load_entry(IndexW'(k), 24'($urandom));

    // first phase fills the chain behind a long receiver hold-off
    run_phase(COUNT_RESET, 300, 1'b1, 1'b0);
    run_phase(CountW'(511), 60, 1'b0, 1'b1);
    run_phase('0, 50, 1'b0, 1'b0);
    run_phase(CountW'(1), 50, 1'b0, 1'b0);
    run_phase(CountW'(257), 60, 1'b0, 1'b0);
    run_phase(CountW'($urandom_range(2, 255)), 80, 1'b0, 1'b0);
    run_phase(CountW'($urandom_range(2, 255)), 80, 1'b0, 1'b0);

    block_idle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
